/* hw/rtl/mps_pkg.sv */
// ----------------------------------------------------------------------------
// Mandelbrot pixel shader package
// Shared types, register indexes and constants of the escape-time core.
// ----------------------------------------------------------------------------
package mps_pkg;

  localparam int MAX_ITERATIONS_DEFAULT = 500;
  localparam int GREY_LEVELS_DEFAULT    = 23;
  localparam int GREY_BASE              = 232;
  localparam int FRAC_BITS              = 24;

  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_STEP     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_X = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_Y = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_COLUMNS  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ROWS     = 3'd4;

  localparam logic [30:0] STEP_RESET    = 31'd1048576;
  localparam logic [10:0] COLUMNS_RESET = 11'd80;
  localparam logic [10:0] ROWS_RESET    = 11'd24;

  typedef struct packed {
    logic [9:0] col;
    logic [9:0] row;
  } pixel_t;

  typedef struct packed {
    logic [8:0] escape_count;
    logic [7:0] grey_color;
  } result_t;

  typedef struct packed {
    logic [CFG_INDEX_W-1:0] index;
    logic [31:0]            wdata;
  } cfg_req_t;

  typedef struct packed {
    logic        [30:0] step;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic        [10:0] columns;
    logic        [10:0] rows;
  } cfg_t;

endpackage

/* hw/rtl/mps_chan_if.sv */
// ----------------------------------------------------------------------------
// Valid/ready channel
// One request moves at a clock edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface mps_chan_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

/* hw/rtl/mps_mul.sv */
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed 32x32 multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module mps_mul (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

/* hw/rtl/mps_cfg.sv */
// ----------------------------------------------------------------------------
// Configuration registers
// Holds step, offsets and screen size; every write request is taken at once.
// ----------------------------------------------------------------------------
module mps_cfg import mps_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  mps_chan_if.sink      cfg,
  output cfg_t          regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.step     <= STEP_RESET;
      regs.offset_x <= '0;
      regs.offset_y <= '0;
      regs.columns  <= COLUMNS_RESET;
      regs.rows     <= ROWS_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.data.index)
        REG_STEP:     regs.step     <= cfg.data.wdata[30:0];
        REG_OFFSET_X: regs.offset_x <= $signed(cfg.data.wdata);
        REG_OFFSET_Y: regs.offset_y <= $signed(cfg.data.wdata);
        REG_COLUMNS:  regs.columns  <= cfg.data.wdata[10:0];
        REG_ROWS:     regs.rows     <= cfg.data.wdata[10:0];
        default: begin
        end
      endcase
    end
  end

endmodule

/* hw/rtl/mps_seq.sv */
// ----------------------------------------------------------------------------
// Escape-time sequencer
// Maps a pixel to the plane, iterates z = z*z + c on the shared multiplier
// and scales the escape count to a grey level held in the result register.
// ----------------------------------------------------------------------------
module mps_seq import mps_pkg::*; #(
  parameter int MAX_ITERATIONS = MAX_ITERATIONS_DEFAULT,
  parameter int GREY_LEVELS    = GREY_LEVELS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               regs,
  mps_chan_if.sink           pixel,
  mps_chan_if.source         result,
  output logic signed [31:0] mul_a,
  output logic signed [31:0] mul_b,
  input  logic signed [63:0] prod
);

  localparam int IterW   = $clog2(MAX_ITERATIONS);
  localparam int QuoW    = $clog2(GREY_LEVELS);
  localparam int NumMax  = 2 * (MAX_ITERATIONS - 1) * (GREY_LEVELS - 1) + (MAX_ITERATIONS - 1);
  localparam int NumW    = $clog2(NumMax + 1);
  localparam int Den     = 2 * (MAX_ITERATIONS - 1);
  localparam int RecipSh = NumW + $clog2(Den);

  localparam longint RecipL = ((longint'(1) << RecipSh) + longint'(Den) - 1) / longint'(Den);

  localparam logic signed [31:0] GreyMul    = 32'(2 * (GREY_LEVELS - 1));
  localparam logic signed [31:0] Recip      = 32'(RecipL);
  localparam logic [63:0]        EscapeLim  = 64'd4 << (2 * FRAC_BITS);
  localparam logic [IterW-1:0]   LastIter   = IterW'(MAX_ITERATIONS - 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MAPX = 4'd1;
  localparam logic [3:0] S_MAPY = 4'd2;
  localparam logic [3:0] S_MAPC = 4'd3;
  localparam logic [3:0] S_RR   = 4'd4;
  localparam logic [3:0] S_II   = 4'd5;
  localparam logic [3:0] S_RI   = 4'd6;
  localparam logic [3:0] S_UPD  = 4'd7;
  localparam logic [3:0] S_CMUL = 4'd8;
  localparam logic [3:0] S_CADD = 4'd9;
  localparam logic [3:0] S_CDIV = 4'd10;
  localparam logic [3:0] S_CQUO = 4'd11;
  localparam logic [3:0] S_FIN  = 4'd12;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  logic [3:0]         state;
  logic [9:0]         col;
  logic [9:0]         row;
  logic signed [31:0] cr;
  logic signed [31:0] ci;
  logic signed [31:0] zr;
  logic signed [31:0] zi;
  logic signed [63:0] rr;
  logic signed [63:0] diff;
  logic               esc;
  logic [IterW-1:0]   iter;
  logic [IterW-1:0]   count;
  logic [NumW-1:0]    rem;
  logic [QuoW-1:0]    quo;
  logic               res_valid;
  logic               res_load;
  result_t            res_data;

  logic signed [11:0] dx;
  logic signed [11:0] dy;
  logic signed [63:0] half_x;
  logic signed [63:0] re_shift;
  logic signed [63:0] im_shift;
  logic signed [63:0] re_next;
  logic signed [63:0] im_next;
  logic [63:0]        mag;
  logic [IterW+8:0]   count_ext;

  assign dx        = $signed({1'b0, col, 1'b0}) - $signed({1'b0, regs.columns});
  assign dy        = $signed({1'b0, row, 1'b0}) - $signed({1'b0, regs.rows});
  assign half_x    = prod >>> 1;
  assign re_shift  = diff >>> FRAC_BITS;
  assign im_shift  = prod >>> (FRAC_BITS - 1);
  assign re_next   = re_shift + 64'(cr);
  assign im_next   = im_shift + 64'(ci);
  assign mag       = $unsigned(rr) + $unsigned(prod);
  assign count_ext = {9'b0, count};
  assign res_load  = (state == S_FIN) && (!res_valid || result.ready);

  always_comb begin
    unique case (state)
      S_MAPX: begin
        mul_a = 32'(dx);
        mul_b = $signed({1'b0, regs.step});
      end
      S_MAPY: begin
        mul_a = 32'(dy);
        mul_b = $signed({1'b0, regs.step});
      end
      S_II: begin
        mul_a = zi;
        mul_b = zi;
      end
      S_RI: begin
        mul_a = zr;
        mul_b = zi;
      end
      S_CMUL: begin
        mul_a = $signed(32'(count));
        mul_b = GreyMul;
      end
      S_CDIV: begin
        mul_a = $signed(32'(rem));
        mul_b = Recip;
      end
      default: begin
        mul_a = zr;
        mul_b = zr;
      end
    endcase
  end

  assign pixel.ready  = (state == S_IDLE);
  assign result.valid = res_valid;
  assign result.data  = res_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && result.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pixel.valid) begin
            col   <= pixel.data.col;
            row   <= pixel.data.row;
            state <= S_MAPX;
          end
        end
        S_MAPX: begin
          state <= S_MAPY;
        end
        S_MAPY: begin
          cr    <= sat32(half_x + 64'(regs.offset_x));
          state <= S_MAPC;
        end
        S_MAPC: begin
          ci    <= sat32(prod + 64'(regs.offset_y));
          zr    <= '0;
          zi    <= '0;
          iter  <= '0;
          state <= S_RR;
        end
        S_RR: begin
          state <= S_II;
        end
        S_II: begin
          rr    <= prod;
          state <= S_RI;
        end
        S_RI: begin
          esc   <= (mag >= EscapeLim);
          diff  <= rr - prod;
          state <= S_UPD;
        end
        S_UPD: begin
          if (esc) begin
            count <= iter;
            state <= S_CMUL;
          end else if (iter == LastIter) begin
            count <= '0;
            state <= S_CMUL;
          end else begin
            zr    <= sat32(re_next);
            zi    <= sat32(im_next);
            iter  <= iter + 1'b1;
            state <= S_RR;
          end
        end
        S_CMUL: begin
          state <= S_CADD;
        end
        S_CADD: begin
          rem   <= prod[NumW-1:0] + NumW'(MAX_ITERATIONS - 1);
          state <= S_CDIV;
        end
        S_CDIV: begin
          state <= S_CQUO;
        end
        S_CQUO: begin
          quo   <= prod[RecipSh +: QuoW];
          state <= S_FIN;
        end
        S_FIN: begin
          if (res_load) begin
            res_data.escape_count <= count_ext[8:0];
            res_data.grey_color   <= 8'(GREY_BASE) + 8'(quo);
            state                 <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/mandelbrot_pixel_shader_core.sv */
// ----------------------------------------------------------------------------
// Mandelbrot pixel shader core
// Escape-time Mandelbrot evaluator for one pixel per request, Q8.24 fixed point.
//
// Channels: pixel takes a request of col and row, result returns one request
// of escape_count and grey_color per pixel, cfg writes step, offset_x,
// offset_y, columns and rows by index and is always ready.
// A pixel's time from acceptance until its result is in the output register
// grows with n, where n is the escape count, or MAX_ITERATIONS-1 when the
// point does not escape. The single 32x32 multiplier computes three products
// per iteration, followed by an update step.
// The pixel channel is ready only while the sequencer is idle. A finished
// result sits in an output register, so the next pixel is accepted while the
// receiver stalls; the sequencer holds a second result until that register
// is free. Reset empties the result register, returns the sequencer to idle
// and loads the register reset values.
// ----------------------------------------------------------------------------
module mandelbrot_pixel_shader_core import mps_pkg::*; #(
  parameter int MAX_ITERATIONS = MAX_ITERATIONS_DEFAULT,
  parameter int GREY_LEVELS    = GREY_LEVELS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  mps_chan_if.sink   cfg,
  mps_chan_if.sink   pixel,
  mps_chan_if.source result
);

  cfg_t               regs;
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] prod;

  mps_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  mps_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  mps_seq #(
    .MAX_ITERATIONS (MAX_ITERATIONS),
    .GREY_LEVELS    (GREY_LEVELS)
  ) u_seq (
    .clk    (clk),
    .rst    (rst),
    .regs   (regs),
    .pixel  (pixel),
    .result (result),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod   (prod)
  );

endmodule
